>>> sv/pbsalu_pkg.sv
// Package: types and constants for the packed byte SIMD ALU.
`timescale 1ns / 1ps

package pbsalu_pkg;

  localparam int unsigned LANES = 4;

  // Operation codes
  localparam logic [3:0] OP_ADD     = 4'd0;
  localparam logic [3:0] OP_SUB     = 4'd1;
  localparam logic [3:0] OP_ABSDIFF = 4'd2;
  localparam logic [3:0] OP_SATADD  = 4'd3;
  localparam logic [3:0] OP_AVG     = 4'd4;
  localparam logic [3:0] OP_MAX     = 4'd5;
  localparam logic [3:0] OP_MIN     = 4'd6;
  localparam logic [3:0] OP_CMPEQ   = 4'd7;
  localparam logic [3:0] OP_CMPGT   = 4'd8;
  localparam logic [3:0] OP_MULU    = 4'd9;
  localparam logic [3:0] OP_MULSU   = 4'd10;
  localparam logic [3:0] OP_SATPACK = 4'd11;

  localparam logic [7:0] LANE_MAX = 8'hff;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [31:0] src_a;
    logic [31:0] src_b;
  } req_t;

  typedef struct packed {
    logic [31:0] dst_even;
    logic [31:0] dst_odd;
  } result_t;

  // What one lane hands to the merge stage
  typedef struct packed {
    logic [7:0]  val;
    logic        hit;
    logic [15:0] prod;
  } lane_res_t;

endpackage

>>> sv/packed_byte_simd_alu.sv
// Module: top level of the packed 4x8 SIMD ALU, lanes plus merge, two-stage pipeline.
//
//  channel   direction  handshake            payload
//  request   in         start, busy          req    (req_t)
//  result    out        done (one cycle)     result (result_t)
//
//  An item is taken at any edge with start high; busy is never raised.
//  Lane results are registered first, then the merged words.
//  One item per cycle sustained.
//  Synchronous reset clears the valid flags only; data registers are not reset.
//  The receiver cannot stall: done lasts one cycle and the result is taken then.
`timescale 1ns / 1ps

module packed_byte_simd_alu
  import pbsalu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  req_t    req,
  output logic    done,
  output result_t result
);

  lane_res_t  lane_now [LANES];
  lane_res_t  lane_q   [LANES];
  logic [3:0] s1_op;
  logic       s1_valid;
  result_t    merged;
  logic       take;

  assign busy = 1'b0;
  assign take = start && !busy;

  // Lanes work side by side on the incoming item
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [15:0] half;
    if (i < 2) begin : g_hb
      assign half = req.src_b[16*i +: 16];
    end else begin : g_ha
      assign half = req.src_a[16*(i-2) +: 16];
    end
    pbsalu_lane u_lane (
      .op   (req.req_type),
      .a    (req.src_a[8*i +: 8]),
      .b    (req.src_b[8*i +: 8]),
      .half (half),
      .res  (lane_now[i])
    );
  end

  // Hold lane results and the opcode
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    s1_op  <= req.req_type;
    lane_q <= lane_now;
  end

  pbsalu_merge u_merge (
    .op       (s1_op),
    .lane_res (lane_q),
    .result   (merged)
  );

  // Advance the merged words to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= merged;
  end

`ifndef SYNTHESIS
  a_take_reaches_s1: assert property (@(posedge clk) disable iff (rst)
    take |=> s1_valid)
    else $error("accepted item did not reach the lane register");

  a_s1_reaches_done: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> done)
    else $error("lane result was not delivered");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s1_valid))
    else $error("result strobe without an item in flight");

  a_odd_only_mul: assert property (@(posedge clk) disable iff (rst)
    (done && (result.dst_odd != 32'd0)) |-> ($past(s1_op) == OP_MULU || $past(s1_op) == OP_MULSU))
    else $error("odd word set for a non-multiply item");
`endif

endmodule

>>> sv/pbsalu_lane.sv
// Module: one byte lane of the SIMD ALU (byte ops, compare, multiply, pack).
`timescale 1ns / 1ps

module pbsalu_lane
  import pbsalu_pkg::*;
(
  input  logic [3:0]  op,
  input  logic [7:0]  a,
  input  logic [7:0]  b,
  input  logic [15:0] half,
  output lane_res_t   res
);

  logic [8:0]  sum;
  logic [8:0]  sum_rnd;
  logic [8:0]  diff;
  logic        a_ge_b;
  logic [8:0]  mul_a;
  logic [17:0] mul_p;
  logic [7:0]  packed_val;

  // Shared adder and subtractor for the byte operations
  assign sum     = {1'b0, a} + {1'b0, b};
  assign sum_rnd = sum + 9'd1;
  assign diff    = {1'b0, a} - {1'b0, b};
  assign a_ge_b  = ~diff[8];

  // Single 9x9 signed multiplier serves both multiply flavours
  assign mul_a = (op == OP_MULSU) ? {a[7], a} : {1'b0, a};
  assign mul_p = 18'($signed(mul_a) * $signed({1'b0, b}));

  // Clamp a signed halfword into an unsigned byte
  always_comb begin
    if (half[15]) begin
      packed_val = 8'd0;
    end else if (half[14:8] != 7'd0) begin
      packed_val = LANE_MAX;
    end else begin
      packed_val = half[7:0];
    end
  end

  // Select the lane byte result, the compare bit and the product
  always_comb begin
    res.hit  = (op == OP_CMPEQ) ? (a == b) : (a_ge_b && (diff[7:0] != 8'd0));
    res.prod = mul_p[15:0];
    case (op)
      OP_ADD:     res.val = sum[7:0];
      OP_SUB:     res.val = diff[7:0];
      OP_ABSDIFF: res.val = a_ge_b ? diff[7:0] : 8'(b - a);
      OP_SATADD:  res.val = sum[8] ? LANE_MAX : sum[7:0];
      OP_AVG:     res.val = sum_rnd[8:1];
      OP_MAX:     res.val = a_ge_b ? a : b;
      OP_MIN:     res.val = a_ge_b ? b : a;
      OP_SATPACK: res.val = packed_val;
      default:    res.val = 8'd0;
    endcase
  end

endmodule

>>> sv/pbsalu_merge.sv
// Module: merge stage that assembles the lane results into the two result words.
`timescale 1ns / 1ps

module pbsalu_merge
  import pbsalu_pkg::*;
(
  input  logic [3:0] op,
  input  lane_res_t  lane_res [LANES],
  output result_t    result
);

  logic [LANES-1:0] hits;

  // Gather compare bits
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      hits[i] = lane_res[i].hit;
    end
  end

  // Pick the word layout by operation class
  always_comb begin
    case (op)
      OP_ADD, OP_SUB, OP_ABSDIFF, OP_SATADD, OP_AVG, OP_MAX, OP_MIN, OP_SATPACK: begin
        result.dst_even = {lane_res[3].val, lane_res[2].val,
                           lane_res[1].val, lane_res[0].val};
        result.dst_odd  = 32'd0;
      end
      OP_CMPEQ, OP_CMPGT: begin
        result.dst_even = {{(32 - LANES){1'b0}}, hits};
        result.dst_odd  = 32'd0;
      end
      OP_MULU, OP_MULSU: begin
        result.dst_even = {lane_res[1].prod, lane_res[0].prod};
        result.dst_odd  = {lane_res[3].prod, lane_res[2].prod};
      end
      default: begin
        result.dst_even = 32'd0;
        result.dst_odd  = 32'd0;
      end
    endcase
  end

endmodule
